FILE: rtl/cpt_pkg.sv
// Shared constants, types and helper functions for the Clarke/Park transform block.
package cpt_pkg;

    localparam int ANGLE_BITS    = 12;
    localparam int DATA_BITS     = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int QUARTER_STEPS = 1 << (ANGLE_BITS - 2);
    localparam int ROM_DEPTH     = QUARTER_STEPS + 1;
    localparam int ROM_AW        = ANGLE_BITS - 1;
    localparam int MAG_BITS      = DATA_BITS - 1;
    localparam int INV_SQRT3_Q16 = 37837;
    localparam int SAMPLE_MAX    = 32767;
    localparam int SAMPLE_MIN    = -32768;
    localparam int LATENCY       = 5;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DATA_BITS-1:0]   trig_t;
    typedef logic [MAG_BITS-1:0]           mag_t;
    typedef logic [ANGLE_BITS-1:0]         angle_t;
    typedef logic [ROM_AW-1:0]             addr_t;
    typedef mag_t                          sine_tbl_t [ROM_DEPTH];

    typedef enum logic [0:0] {
        CFG_BETA_NEGATE   = 1'b0,
        CFG_ANGLE_REVERSE = 1'b1
    } cfg_index_t;

    // term * x^2 in Q30, each product truncated toward zero
    function automatic longint times_x_sq(input longint term, input longint x);
        longint t;
        t = (term * x) / ONE_Q30;
        return (t * x) / ONE_Q30;
    endfunction

    // Quarter-wave sine magnitudes: Q30 Taylor series, rounded to the table scale.
    function automatic sine_tbl_t build_sine_table();
        sine_tbl_t tbl;
        longint    x;
        longint    term;
        longint    sum;
        longint    v;
        longint    amp;
        int        k;
        amp = (longint'(1) << (DATA_BITS - 1)) - 1;
        for (k = 0; k < ROM_DEPTH; k++)
        begin
            x    = (HALF_PI_Q30 * longint'(k)) >>> (ANGLE_BITS - 2);
            term = x;
            sum  = x;
            // terms up to x^19, divisors (2n)(2n+1)
            term = -times_x_sq(term, x) / 64'sd6;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd20;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd42;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd72;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd110;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd156;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd210;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd272;
            sum  = sum + term;
            term = -times_x_sq(term, x) / 64'sd342;
            sum  = sum + term;
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (sum * amp + ONE_Q30 / 2) / ONE_Q30;
            if (v > amp)
            begin
                v = amp;
            end
            tbl[k] = MAG_BITS'(v);
        end
        return tbl;
    endfunction

    // Fold a full-turn angle onto the quarter-wave table address.
    function automatic addr_t quarter_addr(input angle_t a);
        addr_t idx;
        idx = {1'b0, a[ANGLE_BITS-3:0]};
        if (a[ANGLE_BITS-2])
        begin
            return ROM_AW'(QUARTER_STEPS) - idx;
        end
        return idx;
    endfunction

    function automatic sample_t sat_sample(input logic signed [63:0] v);
        if (v > 64'(SAMPLE_MAX))
        begin
            return sample_t'(SAMPLE_MAX);
        end
        if (v < 64'(SAMPLE_MIN))
        begin
            return sample_t'(SAMPLE_MIN);
        end
        return sample_t'(v);
    endfunction

endpackage

FILE: rtl/cpt_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module cpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: rtl/cpt_rotate.sv
// Three-stage vector rotation: out0 = x*c + y*s, out1 = y*c - x*s, rounded and saturated.
module cpt_rotate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  cpt_pkg::sample_t x,
    input  cpt_pkg::sample_t y,
    input  cpt_pkg::trig_t   c,
    input  cpt_pkg::trig_t   s,
    output logic             out_vld,
    output cpt_pkg::sample_t out0,
    output cpt_pkg::sample_t out1
);

    import cpt_pkg::*;

    localparam int PW = SAMPLE_BITS + DATA_BITS;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) << (DATA_BITS - 2);

    logic                 vld_a_reg, vld_b_reg, vld_c_reg;
    logic signed [PW-1:0] p_xc_reg, p_ys_reg, p_yc_reg, p_xs_reg;
    logic signed [PW-1:0] p_xc_next, p_ys_next, p_yc_next, p_xs_next;
    logic signed [SW-1:0] sum0_reg, sum1_reg, sum0_next, sum1_next;
    logic signed [SW-1:0] rnd0, rnd1;
    sample_t              out0_reg, out1_reg, out0_next, out1_next;

    assign p_xc_next = PW'(x) * PW'(c);
    assign p_ys_next = PW'(y) * PW'(s);
    assign p_yc_next = PW'(y) * PW'(c);
    assign p_xs_next = PW'(x) * PW'(s);

    assign sum0_next = SW'(p_xc_reg) + SW'(p_ys_reg);
    assign sum1_next = SW'(p_yc_reg) - SW'(p_xs_reg);

    // round half up, drop the table fraction bits
    assign rnd0      = (sum0_reg + HALF_LSB) >>> (DATA_BITS - 1);
    assign rnd1      = (sum1_reg + HALF_LSB) >>> (DATA_BITS - 1);
    assign out0_next = sat_sample(64'(rnd0));
    assign out1_next = sat_sample(64'(rnd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_xc_reg <= p_xc_next;
        p_ys_reg <= p_ys_next;
        p_yc_reg <= p_yc_next;
        p_xs_reg <= p_xs_next;
        sum0_reg <= sum0_next;
        sum1_reg <= sum1_next;
        out0_reg <= out0_next;
        out1_reg <= out1_next;
    end

    assign out_vld = vld_c_reg;
    assign out0    = out0_reg;
    assign out1    = out1_reg;

endmodule

FILE: rtl/clarke_park_transform.sv
// Top level: Clarke, Park and inverse Park transform pipeline.
//
// Usage:
//   Pulse start with the phase currents, rotor angle and d/q voltage commands;
//   the item is taken at a clock edge where start is high and busy is low.
//   A new item may be taken on every clock, so one transform per cycle is
//   sustained. Results (current_d/q, volt_alpha/beta) appear together with a
//   one-cycle done strobe, in order, once the transfer has passed every stage.
//   The pipeline runs two stages of angle/sine lookup and beta scaling, then
//   three stages of multiply, sum, and round/saturate.
//   Results cannot be held off: done marks the only cycle they are valid.
//   Configuration (beta_negate, angle_reverse) is written through cfg_we /
//   cfg_index / cfg_wdata while no item is in flight; both reset to 0.
//   After reset the quarter-wave sine RAM is loaded from a constant table,
//   one entry per cycle: busy stays high after rst_n rises until all 1025
//   entries (table depth) are written, then drops and stays low.
module clarke_park_transform (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      done,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [0:0]                cfg_wdata,
    input  cpt_pkg::sample_t          phase_a_current,
    input  cpt_pkg::sample_t          phase_b_current,
    input  logic [11:0]               rotor_angle,
    input  cpt_pkg::sample_t          volt_d_cmd,
    input  cpt_pkg::sample_t          volt_q_cmd,
    output cpt_pkg::sample_t          current_d,
    output cpt_pkg::sample_t          current_q,
    output cpt_pkg::sample_t          volt_alpha,
    output cpt_pkg::sample_t          volt_beta
);

    import cpt_pkg::*;

    localparam sine_tbl_t SINE_TABLE = build_sine_table();
    localparam int ABW = SAMPLE_BITS + 2;       // ia + 2*ib
    localparam int BPW = ABW + 17;              // times Q16 1/sqrt3
    localparam logic signed [BPW-1:0] HALF_Q16 = BPW'(1) << 15;

    // configuration
    logic beta_negate_reg, angle_reverse_reg;

    // table load
    logic  fill_active_reg, fill_active_next;
    addr_t fill_cnt_reg, fill_cnt_next;

    // angle and table read
    angle_t ang_s, ang_c;
    addr_t  sin_addr, cos_addr;
    mag_t   sin_mag, cos_mag;
    logic   accept;

    // stage 1
    logic                  v1_reg;
    logic signed [BPW-1:0] prod1_reg, prod1_next;
    logic signed [ABW-1:0] ab_sum;
    sample_t               ia1_reg, vd1_reg, vq1_reg;
    logic                  sneg1_reg, cneg1_reg;

    // stage 2
    logic                  v2_reg;
    logic signed [BPW-1:0] beta_rnd, beta_sgn;
    sample_t               beta2_reg, beta2_next;
    sample_t               ia2_reg, vd2_reg, vq2_reg;
    trig_t                 sin_pos, cos_pos;
    trig_t                 sin2_reg, nsin2_reg, cos2_reg;
    trig_t                 sin2_next, nsin2_next, cos2_next;

    // rotation outputs
    logic park_vld, ipark_vld;

    assign accept = start && !busy;
    assign busy   = fill_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_negate_reg   <= 1'b0;
            angle_reverse_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BETA_NEGATE:   beta_negate_reg   <= cfg_wdata[0];
                CFG_ANGLE_REVERSE: angle_reverse_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        fill_cnt_next    = fill_cnt_reg;
        fill_active_next = fill_active_reg;
        if (fill_active_reg)
        begin
            if (fill_cnt_reg == ROM_AW'(QUARTER_STEPS))
            begin
                fill_active_next = 1'b0;
            end
            else
            begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b1;
            fill_cnt_reg    <= '0;
        end
        else
        begin
            fill_active_reg <= fill_active_next;
            fill_cnt_reg    <= fill_cnt_next;
        end
    end

    // cosine is the sine a quarter turn later
    assign ang_s    = angle_reverse_reg ? (ANGLE_BITS'(0) - rotor_angle[ANGLE_BITS-1:0])
                                        : rotor_angle[ANGLE_BITS-1:0];
    assign ang_c    = ang_s + ANGLE_BITS'(QUARTER_STEPS);
    assign sin_addr = quarter_addr(ang_s);
    assign cos_addr = quarter_addr(ang_c);

    cpt_ram #(
        .WIDTH (MAG_BITS),
        .DEPTH (ROM_DEPTH)
    ) u_sine_ram (
        .clk     (clk),
        .we      (fill_active_reg),
        .waddr   (fill_cnt_reg),
        .wdata   (SINE_TABLE[fill_cnt_reg]),
        .raddr_a (sin_addr),
        .raddr_b (cos_addr),
        .rdata_a (sin_mag),
        .rdata_b (cos_mag)
    );

    // stage 1: table read in flight, beta product
    assign ab_sum     = ABW'(phase_a_current) + (ABW'(phase_b_current) <<< 1);
    assign prod1_next = BPW'(ab_sum) * BPW'(INV_SQRT3_Q16);

    // stage 2: beta round/negate/saturate, signed sine and cosine
    assign beta_rnd   = (prod1_reg + HALF_Q16) >>> 16;
    assign beta_sgn   = beta_negate_reg ? -beta_rnd : beta_rnd;
    assign beta2_next = sat_sample(64'(beta_sgn));
    assign sin_pos    = trig_t'({1'b0, sin_mag});
    assign cos_pos    = trig_t'({1'b0, cos_mag});
    assign sin2_next  = sneg1_reg ? -sin_pos : sin_pos;
    assign nsin2_next = sneg1_reg ? sin_pos : -sin_pos;
    assign cos2_next  = cneg1_reg ? -cos_pos : cos_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        ia1_reg   <= phase_a_current;
        vd1_reg   <= volt_d_cmd;
        vq1_reg   <= volt_q_cmd;
        sneg1_reg <= ang_s[ANGLE_BITS-1];
        cneg1_reg <= ang_c[ANGLE_BITS-1];
        beta2_reg <= beta2_next;
        ia2_reg   <= ia1_reg;
        vd2_reg   <= vd1_reg;
        vq2_reg   <= vq1_reg;
        sin2_reg  <= sin2_next;
        nsin2_reg <= nsin2_next;
        cos2_reg  <= cos2_next;
    end

    // Park: id = a*c + b*s, iq = b*c - a*s
    cpt_rotate u_park (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (v2_reg),
        .x       (ia2_reg),
        .y       (beta2_reg),
        .c       (cos2_reg),
        .s       (sin2_reg),
        .out_vld (park_vld),
        .out0    (current_d),
        .out1    (current_q)
    );

    // inverse Park is the same rotation with the sine negated
    cpt_rotate u_ipark (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (v2_reg),
        .x       (vd2_reg),
        .y       (vq2_reg),
        .c       (cos2_reg),
        .s       (nsin2_reg),
        .out_vld (ipark_vld),
        .out0    (volt_alpha),
        .out1    (volt_beta)
    );

    assign done = park_vld;

    a_rot_vld_match: assert property (@(posedge clk) disable iff (!rst_n)
        park_vld == ipark_vld)
        else $error("rotation pipelines out of step");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done without a transfer five cycles earlier");

    a_no_done_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done && !v1_reg && !v2_reg)
        else $error("pipeline active during table load");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= ROM_AW'(QUARTER_STEPS))
        else $error("table load counter past last entry");

endmodule
